// ===== hdl/tgi_pkg.sv =====
package tgi_pkg;

  localparam int TIME_BITS  = 24;
  localparam int MAX_GAP    = 63;
  localparam int TDATA_BITS = ((TIME_BITS + 7) / 8) * 8;
  localparam int GAP_BITS   = $clog2(MAX_GAP + 1);
  localparam int DEN_BITS   = $clog2(MAX_GAP + 2);
  localparam int CNT_BITS   = DEN_BITS;
  localparam int REM_BITS   = DEN_BITS + 1;
  localparam int DVD_BITS   = TIME_BITS + 1;
  localparam int DCNT_BITS  = $clog2(DVD_BITS + 1);

  typedef struct packed {
    logic                done;
    logic [DVD_BITS-1:0] quo;
    logic [REM_BITS-1:0] rem;
  } div_res_t;

endpackage

// ===== hdl/tgi_div.sv =====
module tgi_div import tgi_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [DVD_BITS-1:0] dividend,
  input  logic [REM_BITS-1:0] divisor,
  output div_res_t            res
);

  logic                 busy;
  logic                 done;
  logic [DCNT_BITS-1:0] cnt;
  logic [DVD_BITS-1:0]  quo;
  logic [REM_BITS-1:0]  rem;
  logic [REM_BITS-1:0]  dsor;
  logic [REM_BITS:0]    trial;
  logic                 ge;

  // restoring division, one quotient bit per cycle
  always_comb begin
    trial = {rem, quo[DVD_BITS-1]};
    ge    = trial >= {1'b0, dsor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        quo  <= dividend;
        rem  <= '0;
        dsor <= divisor;
      end else if (busy) begin
        quo <= {quo[DVD_BITS-2:0], ge};
        rem <= ge ? REM_BITS'(trial - {1'b0, dsor}) : trial[REM_BITS-1:0];
        cnt <= cnt + DCNT_BITS'(1);
        if (cnt == DCNT_BITS'(DVD_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign res.done = done;
  assign res.quo  = quo;
  assign res.rem  = rem;

endmodule

// ===== hdl/timestamp_gap_interpolator_top.sv =====
// channel  dir  tdata            tuser                          tlast
// s_*      in   time_ms [23:0]   is_null                        last_item
// m_*      out  out_time_ms      interpolated, gap_overflow     run_last
//
// A null extends the run, no result, unless !seen, at_max or s_tlast.
// A value after n nulls: accept, serial divide of the TIME_BITS + 1 bit
// dividend, step load, then n + 1 results at one per cycle unless stalled.
// A value with no run, or a flushed run, goes straight to the results.
// rst is synchronous and clears the run state and m_tvalid.
// A stalled m_tready holds the result stage and s_tready stays low until
// the last result of the item has been loaded.
module timestamp_gap_interpolator_top import tgi_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [TDATA_BITS-1:0] s_tdata,   // time_ms
  input  logic                  s_tuser,   // is_null
  input  logic                  s_tlast,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [TDATA_BITS-1:0] m_tdata,   // out_time_ms
  output logic [1:0]            m_tuser,   // interpolated, gap_overflow
  output logic                  m_tlast
);

  typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_EMIT} state_t;

  state_t              state;
  logic [TIME_BITS-1:0] last_time;
  logic [GAP_BITS-1:0]  pending;
  logic                 seen;
  logic [TIME_BITS-1:0] new_time;
  logic                 fin;
  logic                 hold;
  logic                 ovf;
  logic                 neg;
  logic [CNT_BITS-1:0]  left;
  logic [REM_BITS-1:0]  msor;
  logic [TIME_BITS-1:0] step_q;
  logic [REM_BITS-1:0]  step_r;
  logic [TIME_BITS-1:0] acc;
  logic [REM_BITS-1:0]  r;
  logic [TIME_BITS-1:0] out_time;
  logic                 out_interp;
  logic                 out_ovf;
  logic                 out_last;

  logic [TIME_BITS-1:0] in_time;
  logic                 accept;
  logic                 in_neg;
  logic [TIME_BITS-1:0] mag;
  logic                 at_max;
  logic                 hold_case;
  logic [DEN_BITS-1:0]  den;
  logic                 div_start;
  div_res_t             div_res;
  logic [REM_BITS:0]    r_sum;
  logic                 carry;
  logic [REM_BITS-1:0]  r_next;
  logic [TIME_BITS-1:0] acc_next;
  logic                 out_free;
  logic                 emit_last;

  always_comb begin
    in_time   = s_tdata[TIME_BITS-1:0];
    accept    = s_tvalid && s_tready;
    in_neg    = in_time < last_time;
    mag       = in_neg ? last_time - in_time : in_time - last_time;
    at_max    = pending >= GAP_BITS'(MAX_GAP);
    hold_case = !seen || at_max || s_tlast;
    den       = DEN_BITS'(pending) + DEN_BITS'(1);
    div_start = accept && !s_tuser && (pending != '0);
    // k-th point: running quotient of (2|d|k + den - neg) / (2 den)
    r_sum     = {1'b0, r} + {1'b0, step_r};
    carry     = r_sum >= {1'b0, msor};
    r_next    = carry ? REM_BITS'(r_sum - {1'b0, msor}) : r_sum[REM_BITS-1:0];
    acc_next  = acc + (neg ? ~step_q : step_q) + TIME_BITS'(neg ^ carry);
    out_free  = !m_tvalid || m_tready;
    emit_last = hold ? (left == CNT_BITS'(1)) : (left == '0);
  end

  tgi_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({mag, 1'b0}),
    .divisor  ({den, 1'b0}),
    .res      (div_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      m_tvalid  <= 1'b0;
      last_time <= '0;
      pending   <= '0;
      seen      <= 1'b0;
    end else begin
      if (m_tready && state != ST_EMIT) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            new_time <= in_time;
            fin      <= s_tlast;
            neg      <= in_neg;
            acc      <= last_time;
            r        <= REM_BITS'(den - DEN_BITS'(in_neg));
            msor     <= {den, 1'b0};
            ovf      <= s_tuser && seen && at_max;
            if (s_tuser) begin
              if (hold_case) begin
                hold  <= 1'b1;
                left  <= CNT_BITS'(den);
                state <= ST_EMIT;
              end else begin
                pending <= pending + GAP_BITS'(1);
              end
            end else begin
              hold  <= 1'b0;
              left  <= CNT_BITS'(pending);
              state <= (pending != '0) ? ST_DIV : ST_EMIT;
            end
          end
        end
        ST_DIV: begin
          if (div_res.done) begin
            step_q <= div_res.quo[TIME_BITS-1:0];
            step_r <= div_res.rem;
            state  <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            out_last <= emit_last;
            if (left != '0) begin
              out_time   <= hold ? last_time : acc_next;
              out_interp <= 1'b1;
              out_ovf    <= ovf;
              left       <= left - CNT_BITS'(1);
              acc        <= acc_next;
              r          <= r_next;
            end else begin
              out_time   <= new_time;
              out_interp <= 1'b0;
              out_ovf    <= 1'b0;
            end
            if (emit_last) begin
              state   <= ST_IDLE;
              pending <= '0;
              if (fin) begin
                last_time <= '0;
                seen      <= 1'b0;
              end else if (!hold) begin
                last_time <= new_time;
                seen      <= 1'b1;
              end
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign s_tready = (state == ST_IDLE);
  assign m_tdata  = TDATA_BITS'(out_time);
  assign m_tuser  = {out_ovf, out_interp};
  assign m_tlast  = out_last;

endmodule

// ===== hdl/tgi_checker.sv =====
module tgi_checker import tgi_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic                  s_tuser,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [TDATA_BITS-1:0] m_tdata,
  input logic [1:0]            m_tuser,
  input logic                  m_tlast
);

  a_rst_clears: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("stalled item changed");

  a_ovf_interp: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> m_tuser[0])
    else $error("overflow item not marked interpolated");

  a_value_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tlast)
    else $error("value item not last of its run");

  a_value_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !s_tuser |=> !s_tready)
    else $error("input taken while value results pending");

endmodule

bind timestamp_gap_interpolator_top tgi_checker u_chk (.*);
